/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with reset disable.
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");
// Clocked next-cycle implication with reset disable.
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

/* rtl/kdtbl_pkg.sv */
// ---------------------------------------------------------------------------
// kdtbl_pkg
// Types, constants and codes of the keyed dual token bucket limiter.
// ---------------------------------------------------------------------------
`default_nettype none
package kdtbl_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned MsPerMin   = 60000;

  // Command codes.
  localparam logic [1:0] CmdConn  = 2'd0;
  localparam logic [1:0] CmdReq   = 2'd1;
  localparam logic [1:0] CmdEvict = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegBurst = 2'd0;
  localparam logic [1:0] RegConn  = 2'd1;
  localparam logic [1:0] RegReq   = 2'd2;
  localparam logic [1:0] RegLimit = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] client_key;
    logic [63:0] time_ms;
    logic [63:0] idle_limit_ms;
  } in_item_t;

  typedef struct packed {
    logic        allowed;
    logic [10:0] removed_count;
    logic [10:0] occupancy;
  } out_item_t;

endpackage
`default_nettype wire

/* rtl/kdtbl_front.sv */
// ---------------------------------------------------------------------------
// kdtbl_front
// Accepts items into a short queue and hands them on to the table engine.
// ---------------------------------------------------------------------------
`default_nettype none
module kdtbl_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  output logic                 full_o,
  input  kdtbl_pkg::in_item_t  item_i,
  output logic                 vld_o,
  input  wire                  take_i,
  output kdtbl_pkg::in_item_t  item_o
);
  kdtbl_pkg::in_item_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q[1];
  assign vld_o  = cnt_q != 2'd0;
  assign item_o = buf_q[rp_q];

  // Two-entry queue; pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (take_i && vld_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, take_i && vld_o};
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) buf_q[wp_q] <= item_i;
  end
endmodule
`default_nettype wire

/* rtl/kdtbl_engine.sv */
// ---------------------------------------------------------------------------
// kdtbl_engine
// Walks the client table for checks and evicts and produces one result.
// ---------------------------------------------------------------------------
`default_nettype none
module kdtbl_engine #(
  parameter int unsigned TABLE_DEPTH = kdtbl_pkg::TableDepth,
  parameter int unsigned FRAC_BITS   = kdtbl_pkg::FracBits
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  vld_i,
  output logic                 take_o,
  input  kdtbl_pkg::in_item_t  item_i,
  input  wire  [15:0]          burst_i,
  input  wire  [15:0]          conn_rate_i,
  input  wire  [15:0]          req_rate_i,
  input  wire  [10:0]          limit_i,
  output logic                 res_vld_o,
  input  wire                  res_take_i,
  output kdtbl_pkg::out_item_t res_o
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TW = 16 + FRAC_BITS;
  // The refill divides by 60000 = 32 * 1875. It is done as a multiply by the
  // rounded-up reciprocal of 1875, which is exact for products below 2^32.
  localparam int unsigned DivOdd = kdtbl_pkg::MsPerMin / 32;
  localparam int unsigned MW     = 28 + FRAC_BITS;
  localparam int unsigned ML     = MW / 2;
  localparam int unsigned MH     = MW - ML;
  localparam int unsigned PLW    = 32 + ML;
  localparam int unsigned PHW    = 32 + MH;
  localparam int unsigned PW     = 32 + MW;
  localparam int unsigned RShift = 43;
  localparam logic [MW-1:0] Recip =
    MW'(((64'd1 << (38 + FRAC_BITS)) / 64'(DivOdd)) + 64'd1);
  localparam logic [63:0] SatElapsed = 64'(kdtbl_pkg::MsPerMin) << 16;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRCH, S_SCMP, S_FLSH, S_FREE, S_FCMP, S_RD, S_MUL,
    S_REC, S_ADD, S_WR, S_EVRD, S_EVCMP, S_OUT
  } state_e;

  // Table memories, valid bits included.
  logic [63:0]   key_mem [TABLE_DEPTH];
  logic [TW-1:0] conn_mem [TABLE_DEPTH];
  logic [TW-1:0] req_mem [TABLE_DEPTH];
  logic [63:0]   last_mem [TABLE_DEPTH];
  logic          valid_mem [TABLE_DEPTH];

  state_e        state_q;
  kdtbl_pkg::in_item_t it_q;
  logic [CW-1:0] cnt_q, removed_q;
  logic [CW:0]   idx_q;
  logic [AW-1:0] slot_q;
  logic [63:0]   rkey_q, rlast_q;
  logic [TW-1:0] rconn_q, rreq_q;
  logic          rvld_q;
  logic [63:0]   el_q;
  logic [47:0]   qc_q, qr_q;
  logic [PLW-1:0] plc_q, plr_q;
  logic [PHW-1:0] phc_q, phr_q;
  logic [TW:0]   quo_c_q, quo_r_q;
  logic          satc_q, satr_q;
  logic          new_q;
  logic          allowed_q;
  kdtbl_pkg::out_item_t res_q;
  logic          res_vld_q;

  logic [AW-1:0] idx_a;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [TW-1:0] cap;
  logic [TW-1:0] one;
  logic [63:0]   el_now;
  logic [10:0]   lim_eff;
  logic          full_now;
  logic          ev_hit;
  logic [PW-1:0] prod_c, prod_r;
  logic [TW+1:0] sum_c, sum_r;
  logic [TW-1:0] base_c, base_r;
  logic [TW-1:0] fc, fr;

  assign idx_a    = idx_q[AW-1:0];
  assign cap      = TW'(burst_i) << FRAC_BITS;
  assign one      = TW'(1) << FRAC_BITS;
  assign el_now   = it_q.time_ms - rlast_q;
  assign lim_eff  = (limit_i == 11'd0) ? 11'd1 : limit_i;
  assign full_now = (32'(cnt_q) >= 32'(lim_eff)) || (32'(cnt_q) >= TABLE_DEPTH);
  assign ev_hit   = rvld_q && ((it_q.time_ms - rlast_q) > it_q.idle_limit_ms);
  assign take_o    = state_q == S_IDLE && vld_i && !res_vld_q;
  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

  // Reciprocal products recombined; the top bits are the refill amount.
  assign prod_c = (PW'(phc_q) << ML) + PW'(plc_q);
  assign prod_r = (PW'(phr_q) << ML) + PW'(plr_q);

  // Bucket sums after refill, clamped to the burst.
  always_comb begin
    base_c = new_q ? cap : rconn_q;
    base_r = new_q ? cap : rreq_q;
    sum_c  = (TW + 2)'(base_c) + (TW + 2)'(quo_c_q);
    sum_r  = (TW + 2)'(base_r) + (TW + 2)'(quo_r_q);
    if (el_q == 64'd0) fc = base_c;
    else if (satc_q || sum_c > (TW + 2)'(cap)) fc = cap;
    else fc = sum_c[TW-1:0];
    if (el_q == 64'd0) fr = base_r;
    else if (satr_q || sum_r > (TW + 2)'(cap)) fr = cap;
    else fr = sum_r[TW-1:0];
  end

  assign rd_en   = state_q == S_SRCH || state_q == S_EVRD || state_q == S_RD ||
                   state_q == S_FREE;
  assign rd_addr = (state_q == S_RD) ? slot_q : idx_a;

  // Memory reads and writes.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rkey_q  <= key_mem[rd_addr];
      rlast_q <= last_mem[rd_addr];
      rconn_q <= conn_mem[rd_addr];
      rreq_q  <= req_mem[rd_addr];
      rvld_q  <= valid_mem[rd_addr];
    end
    if (state_q == S_CLR || state_q == S_FLSH) valid_mem[idx_a] <= 1'b0;
    if (state_q == S_FCMP && !rvld_q) valid_mem[idx_a] <= 1'b1;
    if (state_q == S_EVCMP && ev_hit) valid_mem[idx_a] <= 1'b0;
    if (state_q == S_WR) begin
      key_mem[slot_q]  <= it_q.client_key;
      last_mem[slot_q] <= it_q.time_ms;
      if (it_q.command == kdtbl_pkg::CmdReq) begin
        conn_mem[slot_q] <= fc;
        req_mem[slot_q]  <= (fr >= one) ? fr - one : fr;
      end else begin
        conn_mem[slot_q] <= (fc >= one) ? fc - one : fc;
        req_mem[slot_q]  <= fr;
      end
    end
  end

  // Sequencer: clear, search, allocate, refill, write back, evict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (res_vld_q && res_take_i) res_vld_q <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          if (32'(idx_q) == TABLE_DEPTH - 1) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else idx_q <= idx_q + (CW + 1)'(1);
        end
        S_IDLE: if (take_o) begin
          it_q      <= item_i;
          idx_q     <= '0;
          removed_q <= '0;
          allowed_q <= 1'b0;
          case (item_i.command)
            kdtbl_pkg::CmdConn, kdtbl_pkg::CmdReq: state_q <= S_SRCH;
            kdtbl_pkg::CmdEvict: state_q <= S_EVRD;
            default: state_q <= S_OUT;
          endcase
        end
        S_SRCH: begin
          if (32'(idx_q) >= TABLE_DEPTH) begin
            idx_q <= '0;
            if (full_now) begin
              cnt_q   <= '0;
              state_q <= S_FLSH;
            end else state_q <= S_FREE;
          end else state_q <= S_SCMP;
        end
        S_SCMP: begin
          if (rvld_q && rkey_q == it_q.client_key) begin
            slot_q  <= idx_a;
            new_q   <= 1'b0;
            state_q <= S_RD;
          end else begin
            idx_q   <= idx_q + (CW + 1)'(1);
            state_q <= S_SRCH;
          end
        end
        // A full table is cleared one entry per cycle before allocation.
        S_FLSH: begin
          if (32'(idx_q) == TABLE_DEPTH - 1) begin
            idx_q   <= '0;
            state_q <= S_FREE;
          end else idx_q <= idx_q + (CW + 1)'(1);
        end
        S_FREE: state_q <= S_FCMP;
        S_FCMP: begin
          if (!rvld_q) begin
            slot_q  <= idx_a;
            new_q   <= 1'b1;
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_MUL;
          end else begin
            idx_q   <= idx_q + (CW + 1)'(1);
            state_q <= S_FREE;
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          if (new_q) begin
            el_q <= 64'd0;
            qc_q <= '0;
            qr_q <= '0;
          end else begin
            el_q <= el_now;
            qc_q <= 48'(el_now[31:0]) * 48'(conn_rate_i);
            qr_q <= 48'(el_now[31:0]) * 48'(req_rate_i);
          end
          state_q <= S_REC;
        end
        // Partial products with the reciprocal; large products saturate.
        S_REC: begin
          plc_q   <= PLW'(qc_q[31:0]) * PLW'(Recip[ML-1:0]);
          phc_q   <= PHW'(qc_q[31:0]) * PHW'(Recip[MW-1:ML]);
          plr_q   <= PLW'(qr_q[31:0]) * PLW'(Recip[ML-1:0]);
          phr_q   <= PHW'(qr_q[31:0]) * PHW'(Recip[MW-1:ML]);
          satc_q  <= (conn_rate_i != 16'd0 && el_q >= SatElapsed) || qc_q[47:32] != 16'd0;
          satr_q  <= (req_rate_i != 16'd0 && el_q >= SatElapsed) || qr_q[47:32] != 16'd0;
          state_q <= S_ADD;
        end
        S_ADD: begin
          quo_c_q <= prod_c[PW-1:RShift];
          quo_r_q <= prod_r[PW-1:RShift];
          state_q <= S_WR;
        end
        S_WR: begin
          allowed_q <= (it_q.command == kdtbl_pkg::CmdReq) ? (fr >= one) : (fc >= one);
          state_q   <= S_OUT;
        end
        S_EVRD: begin
          if (32'(idx_q) >= TABLE_DEPTH) state_q <= S_OUT;
          else state_q <= S_EVCMP;
        end
        S_EVCMP: begin
          if (ev_hit) begin
            cnt_q     <= cnt_q - CW'(1);
            removed_q <= removed_q + CW'(1);
          end
          idx_q   <= idx_q + (CW + 1)'(1);
          state_q <= S_EVRD;
        end
        S_OUT: begin
          res_q.allowed       <= allowed_q;
          res_q.removed_count <= 11'(removed_q);
          res_q.occupancy     <= 11'(cnt_q);
          res_vld_q           <= 1'b1;
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/keyed_dual_token_bucket_limiter_core.sv */
// A check searches the table for the key, then refills the buckets and writes them back;
// a new key also searches for a free slot, after the table is first cleared when full;
// an evict scans every entry of the table.
// One item is handled at a time; the next is taken once the last result is popped.
// Reset loads the register defaults and runs a pass over the table that clears
// the valid bits before the first item is taken.
// ---------------------------------------------------------------------------
// keyed_dual_token_bucket_limiter_core
// Top level: config registers, input queue and table engine.
// ---------------------------------------------------------------------------
`default_nettype none
module keyed_dual_token_bucket_limiter_core #(
  parameter int unsigned TABLE_DEPTH = kdtbl_pkg::TableDepth,
  parameter int unsigned FRAC_BITS   = kdtbl_pkg::FracBits
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push,
  output logic                 full,
  input  kdtbl_pkg::in_item_t  in_item_i,
  output logic                 empty,
  input  wire                  pop,
  output kdtbl_pkg::out_item_t out_item_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [15:0]          cfg_data_i
);
  logic [15:0] burst_q, conn_q, req_q;
  logic [10:0] limit_q;
  logic        q_vld, q_take, res_vld;
  kdtbl_pkg::in_item_t q_item;

  assign cfg_ready_o = 1'b1;
  assign empty = !res_vld;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= 16'd10;
      conn_q  <= 16'd60;
      req_q   <= 16'd600;
      limit_q <= 11'd1024;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kdtbl_pkg::RegBurst: burst_q <= cfg_data_i;
        kdtbl_pkg::RegConn:  conn_q  <= cfg_data_i;
        kdtbl_pkg::RegReq:   req_q   <= cfg_data_i;
        kdtbl_pkg::RegLimit: limit_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  kdtbl_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item_i),
    .vld_o(q_vld), .take_i(q_take), .item_o(q_item)
  );

  kdtbl_engine #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_engine (
    .clk_i, .rst_ni, .vld_i(q_vld), .take_o(q_take), .item_i(q_item),
    .burst_i(burst_q), .conn_rate_i(conn_q), .req_rate_i(req_q), .limit_i(limit_q),
    .res_vld_o(res_vld), .res_take_i(pop), .res_o(out_item_o)
  );
endmodule
`default_nettype wire

/* rtl/kdtbl_checker.sv */
// ---------------------------------------------------------------------------
// kdtbl_checker
// Port-level checks of the limiter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module kdtbl_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  empty,
  input wire                  pop,
  input kdtbl_pkg::out_item_t out_item_o
);
  // A result that is not taken stays.
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
  // Occupancy never exceeds the table size.
  `ASSERT_IMPL(a_occ, clk_i, rst_ni, !empty, out_item_o.occupancy <= 11'd1024)
  // A command never both spends a token and removes entries.
  `ASSERT_IMPL(a_excl, clk_i, rst_ni, !empty && out_item_o.allowed,
               out_item_o.removed_count == 11'd0)
endmodule

bind keyed_dual_token_bucket_limiter_core kdtbl_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
`default_nettype wire
